FILE: sv/mlt_pkg.sv
// Shared types and opcodes for the MAC learning table.
`timescale 1ns / 1ps
package mlt_pkg;
  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_AGE    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request fields, clear scan index
    logic step;       // advance scan index
    logic rd;         // issue read at scan index
    logic wr_key;     // write full entry at wr_slot
    logic wr_refresh; // write port and time at wr_slot
    logic clr_valid;  // clear valid at the previous read slot
    logic note_match; // record the slot read last cycle as found
    logic note_free;  // record the slot read last cycle as free
    logic count_age;  // bump aged count
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last;       // scan index is at last entry
    logic rd_valid;   // entry read last cycle was valid
    logic rd_match;   // entry read last cycle holds the key
    logic rd_expired; // entry read last cycle has aged out
    logic found;      // a matching slot has been recorded
    logic have_free;  // a free slot has been recorded
  } stat_t;
endpackage

FILE: sv/mlt_datapath.sv
// Entry storage, scan index and comparators of the MAC learning table.
`timescale 1ns / 1ps
module mlt_datapath #(
  parameter int TABLE_ENTRIES = 256,
  parameter int PORT_BITS     = 8,
  parameter int IW            = $clog2(TABLE_ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mlt_pkg::cmd_t        cmd,
  output mlt_pkg::stat_t       stat,
  input  logic [47:0]          mac_addr,
  input  logic [11:0]          vlan_id,
  input  logic [7:0]           port_in,
  input  logic [31:0]          time_now,
  input  logic [15:0]          max_age,
  output logic [7:0]           port_found,
  output logic [8:0]           aged_cnt
);
  logic [TABLE_ENTRIES-1:0] valid;
  logic [47:0]          mem_mac  [TABLE_ENTRIES];
  logic [11:0]          mem_vlan [TABLE_ENTRIES];
  logic [PORT_BITS-1:0] mem_port [TABLE_ENTRIES];
  logic [31:0]          mem_time [TABLE_ENTRIES];

  logic [47:0]          key_mac;
  logic [11:0]          key_vlan;
  logic [PORT_BITS-1:0] key_port;
  logic [31:0]          key_time;
  logic [IW-1:0]        idx, rd_idx, wr_slot;
  logic [47:0]          rd_mac;
  logic [11:0]          rd_vlan;
  logic [PORT_BITS-1:0] rd_port;
  logic [31:0]          rd_time;
  logic                 rd_v, found, have_free;
  logic [31:0]          age;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_mac  <= mem_mac[idx];
      rd_vlan <= mem_vlan[idx];
      rd_port <= mem_port[idx];
      rd_time <= mem_time[idx];
    end
    if (cmd.wr_key) begin
      mem_mac[wr_slot]  <= key_mac;
      mem_vlan[wr_slot] <= key_vlan;
    end
    if (cmd.wr_key || cmd.wr_refresh) begin
      mem_port[wr_slot] <= key_port;
      mem_time[wr_slot] <= key_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      idx       <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
      aged_cnt  <= '0;
    end else begin
      if (cmd.load) begin
        key_mac   <= mac_addr;
        key_vlan  <= vlan_id;
        key_port  <= PORT_BITS'({8'd0, port_in});
        key_time  <= time_now;
        idx       <= '0;
        found     <= 1'b0;
        have_free <= 1'b0;
        aged_cnt  <= '0;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.rd) rd_idx <= idx;
      rd_v <= valid[idx];
      if (cmd.note_match) begin
        found      <= 1'b1;
        wr_slot    <= rd_idx;
        port_found <= 8'({8'd0, rd_port});
      end
      if (cmd.note_free) begin
        have_free <= 1'b1;
        wr_slot   <= rd_idx;
      end
      if (cmd.wr_key) valid[wr_slot] <= 1'b1;
      if (cmd.clr_valid) valid[rd_idx] <= 1'b0;
      if (cmd.count_age && aged_cnt != 9'd511) aged_cnt <= aged_cnt + 9'd1;
    end
  end

  assign age = key_time - rd_time;
  assign stat.last       = (idx == IW'(TABLE_ENTRIES - 1));
  assign stat.rd_valid   = rd_v;
  assign stat.rd_match   = rd_v && rd_mac == key_mac && rd_vlan == key_vlan;
  assign stat.rd_expired = rd_v && (age > {16'd0, max_age});
  assign stat.found      = found;
  assign stat.have_free  = have_free;
endmodule

FILE: sv/mlt_ctrl.sv
// Sequencer that scans the table for learn, lookup and age requests.
`timescale 1ns / 1ps
module mlt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     opcode,
  input  mlt_pkg::stat_t stat,
  output mlt_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done,
  output logic           res_hit,
  output logic           res_lookup,
  output logic           res_age,
  output logic           res_full
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_WRITE, S_DONE} state_t;
  state_t   state;
  mlt_pkg::op_t op;
  logic     learn_hit;
  logic     scan_first;

  // The previous read's status is judged in every scan cycle but the first, and in drain.
  logic judge;
  assign judge = ((state == S_SCAN && !scan_first) || state == S_DRAIN) && !learn_hit;

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && start;
    cmd.rd   = (state == S_SCAN);
    cmd.step = (state == S_SCAN) && !stat.last;
    if (judge && op != mlt_pkg::OP_AGE) begin
      cmd.note_match = stat.rd_match && !stat.found;
      cmd.note_free  = (op == mlt_pkg::OP_LEARN) && !stat.rd_valid && !stat.have_free
                       && !stat.found;
    end
    if (judge && op == mlt_pkg::OP_AGE) begin
      cmd.clr_valid = stat.rd_expired;
      cmd.count_age = stat.rd_expired;
    end
    if (state == S_WRITE) begin
      cmd.wr_refresh = stat.found;
      cmd.wr_key     = !stat.found && stat.have_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= mlt_pkg::OP_NONE;
      learn_hit <= 1'b0;
      scan_first <= 1'b0;
      busy <= 1'b0;
      done <= 1'b0;
      res_hit <= 1'b0;
      res_lookup <= 1'b0;
      res_age <= 1'b0;
      res_full <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          op         <= mlt_pkg::op_t'(opcode);
          learn_hit  <= 1'b0;
          scan_first <= 1'b1;
          busy       <= 1'b1;
          state      <= (opcode == mlt_pkg::OP_NONE) ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          scan_first <= 1'b0;
          if (stat.last) state <= S_DRAIN;
        end
        S_DRAIN: state <= (op == mlt_pkg::OP_LEARN) ? S_WRITE : S_DONE;
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          res_hit    <= (op == mlt_pkg::OP_LEARN || op == mlt_pkg::OP_LOOKUP)
                        && stat.found;
          res_lookup <= (op == mlt_pkg::OP_LOOKUP) && stat.found;
          res_age    <= (op == mlt_pkg::OP_AGE);
          res_full   <= (op == mlt_pkg::OP_LEARN) && !stat.found && !stat.have_free;
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/mac_learning_table.sv
// Top level of the MAC learning table with aging.
// Sequence: one entry is read per cycle in scan, then drain, a write state for
// learn only, and the done state; opcode 3 goes from idle straight to done.
// Requests: one at a time; start is taken when busy is low, at the earliest in
// the done cycle.
// Reset: synchronous rst empties the table at once and sets max_age to 300;
// done is strobed for one cycle with the results and the receiver cannot stall.
`timescale 1ns / 1ps
module mac_learning_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int PORT_BITS     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [47:0] mac_addr,
  input  logic [11:0] vlan_id,
  input  logic [7:0]  port_in,
  input  logic [31:0] time_now,
  output logic        done,
  output logic        hit,
  output logic [7:0]  port_out,
  output logic [8:0]  aged_count,
  output logic        table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  mlt_pkg::cmd_t  cmd;
  mlt_pkg::stat_t stat;
  logic [15:0] max_age;
  logic [7:0]  port_found;
  logic [8:0]  aged_cnt;
  logic        r_lookup, r_age;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_age <= 16'd300;
    else if (cfg_valid && cfg_ready) max_age <= cfg_data;
  end

  mlt_ctrl u_ctrl (
    .clk, .rst, .start, .opcode, .stat, .cmd, .busy, .done,
    .res_hit(hit), .res_lookup(r_lookup), .res_age(r_age), .res_full(table_full)
  );

  mlt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .PORT_BITS(PORT_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .mac_addr, .vlan_id, .port_in, .time_now,
    .max_age, .port_found, .aged_cnt
  );

  assign port_out   = r_lookup ? port_found : 8'd0;
  assign aged_count = r_age ? aged_cnt : 9'd0;
endmodule

FILE: sv/mlt_checker.sv
// Port-level checker for the MAC learning table, bound to the top level.
`timescale 1ns / 1ps
module mlt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       hit,
  input logic       table_full,
  input logic [7:0] port_out,
  input logic [8:0] aged_count
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy after result");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    done && (hit || table_full) |-> aged_count == 9'd0) else $error("mixed result");
  a_full: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> !hit && port_out == 8'd0) else $error("full with hit");
endmodule

bind mac_learning_table mlt_checker u_chk (
  .clk, .rst, .start, .busy, .done, .hit, .table_full, .port_out, .aged_count
);

FILE: bench/tb_top.sv
// Self-checking testbench for the MAC learning table: directed rows, a fill past capacity, then random requests.
`timescale 1ns / 1ps
module tb_top;
  localparam int ENTRIES  = 256;
  localparam int WD_LIMIT = 6000;

  typedef struct packed {
    logic       hit;
    logic [7:0] port;
    logic [8:0] aged;
    logic       full;
  } answer_t;

  typedef struct {
    mlt_pkg::op_t op;
    logic [47:0]  mac;
    logic [11:0]  vlan;
    logic [7:0]   port;
    logic [31:0]  stamp;
    bit           typed;
    answer_t      ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = '0;
  logic [47:0] mac_addr = '0;
  logic [11:0] vlan_id = '0;
  logic [7:0]  port_in = '0;
  logic [31:0] time_now = '0;
  logic        done;
  logic        hit;
  logic [7:0]  port_out;
  logic [8:0]  aged_count;
  logic        table_full;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  mac_learning_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .mac_addr(mac_addr), .vlan_id(vlan_id), .port_in(port_in),
    .time_now(time_now), .done(done), .hit(hit), .port_out(port_out),
    .aged_count(aged_count), .table_full(table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table and its age limit
  logic [15:0] age_limit;
  bit          slot_used [ENTRIES];
  logic [47:0] slot_mac  [ENTRIES];
  logic [11:0] slot_vlan [ENTRIES];
  logic [7:0]  slot_port [ENTRIES];
  logic [31:0] slot_seen [ENTRIES];

  answer_t pending_answers[$];
  int      fail_count = 0;
  int      idle_cycles = 0;
  int      idle_pct = 0;

  function automatic int find_slot(logic [47:0] m, logic [11:0] v);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_mac[i] == m && slot_vlan[i] == v) return i;
    return -1;
  endfunction

  function automatic answer_t table_apply(mlt_pkg::op_t op, logic [47:0] m,
                                          logic [11:0] v, logic [7:0] p,
                                          logic [31:0] t);
    answer_t a;
    int s;
    logic [31:0] span;
    a = '0;
    case (op)
      mlt_pkg::OP_LEARN: begin
        s = find_slot(m, v);
        if (s >= 0) begin
          slot_port[s] = p;
          slot_seen[s] = t;
          a.hit = 1'b1;
        end else begin
          for (int i = 0; i < ENTRIES && s < 0; i++)
            if (!slot_used[i]) s = i;
          if (s >= 0) begin
            slot_used[s] = 1'b1;
            slot_mac[s]  = m;
            slot_vlan[s] = v;
            slot_port[s] = p;
            slot_seen[s] = t;
          end else begin
            a.full = 1'b1;
          end
        end
      end
      mlt_pkg::OP_LOOKUP: begin
        s = find_slot(m, v);
        if (s >= 0) begin
          a.hit  = 1'b1;
          a.port = slot_port[s];
        end
      end
      mlt_pkg::OP_AGE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          span = t - slot_seen[i];
          if (slot_used[i] && span > {16'd0, age_limit}) begin
            slot_used[i] = 1'b0;
            a.aged++;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Hold start high until the block takes the request
  task automatic issue(mlt_pkg::op_t op, logic [47:0] m, logic [11:0] v,
                       logic [7:0] p, logic [31:0] t, bit typed = 0,
                       answer_t typed_ans = '0);
    answer_t a;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    opcode   <= op;
    mac_addr <= m;
    vlan_id  <= v;
    port_in  <= p;
    time_now <= t;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    a = table_apply(op, m, v, p, t);
    pending_answers.push_back(typed ? typed_ans : a);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic set_age_limit(logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    age_limit = val;
  endtask

  // Results: one strobe per request, compared in order
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = pending_answers.pop_front();
        if (hit !== e.hit) begin
          $error("hit: expected %0h, got %0h", e.hit, hit);
          fail_count++;
        end
        if (port_out !== e.port) begin
          $error("port_out: expected %0h, got %0h", e.port, port_out);
          fail_count++;
        end
        if (aged_count !== e.aged) begin
          $error("aged_count: expected %0d, got %0d", e.aged, aged_count);
          fail_count++;
        end
        if (table_full !== e.full) begin
          $error("table_full: expected %0h, got %0h", e.full, table_full);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no request, result or register write taken
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic answer_t ans(logic h, logic [7:0] p, logic [8:0] c, logic f);
    answer_t a;
    a.hit = h; a.port = p; a.aged = c; a.full = f;
    return a;
  endfunction

  initial begin
    row_t rows[$];
    logic [47:0] pool_mac [24];
    logic [11:0] pool_vlan[24];
    logic [31:0] clock_now;
    logic [47:0] m;
    logic [11:0] v;
    int k, r;
    mlt_pkg::op_t op;

    age_limit = 16'd300;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mlt_pkg::OP_LOOKUP, 48'h0, 12'h0, 8'h00, 32'd0, 1, ans(0, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_NONE, '1, '1, '1, '1, 1, ans(0, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_LEARN, '1, '1, 8'hFF, 32'd100, 1, ans(0, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_LEARN, '1, '1, 8'h0A, 32'd200, 1, ans(1, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_LOOKUP, '1, '1, 8'h00, 32'd0, 1, ans(1, 8'h0A, 0, 0)});
    rows.push_back('{mlt_pkg::OP_LEARN, 48'h0, 12'h0, 8'h00, 32'd0, 1, ans(0, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_LOOKUP, 48'h0, 12'h0, 8'hFF, 32'd0, 1, ans(1, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_LEARN, 48'hAAAA_AAAA_AAAA, 12'h555, 8'h55, 32'hFFFF_FFF0,
                     0, '0});
    rows.push_back('{mlt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, 12'hAAA, 8'h00, 32'd0, 1,
                     ans(0, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_LOOKUP, 48'hAAAA_AAAA_AAAA, 12'h555, 8'h00, 32'd0, 0, '0});
    rows.push_back('{mlt_pkg::OP_AGE, 48'h0, 12'h0, 8'h00, 32'd250, 1, ans(0, 0, 0, 0)});
    rows.push_back('{mlt_pkg::OP_AGE, 48'h0, 12'h0, 8'h00, 32'h10, 0, '0});
    rows.push_back('{mlt_pkg::OP_AGE, 48'h0, 12'h0, 8'h00, 32'hFFFF_FFFF, 0, '0});
    rows.push_back('{mlt_pkg::OP_LOOKUP, 48'h0, 12'h0, 8'h00, 32'd0, 0, '0});
    rows.push_back('{mlt_pkg::OP_LEARN, 48'h5555_5555_5555, 12'hAAA, 8'hAA, 32'd12345,
                     0, '0});
    rows.push_back('{mlt_pkg::OP_AGE, '1, '1, '1, 32'h8000_0000, 0, '0});
    rows.push_back('{mlt_pkg::OP_LOOKUP, 48'h5555_5555_5555, 12'hAAA, 8'h00, 32'd0, 0, '0});
    foreach (rows[i])
      issue(rows[i].op, rows[i].mac, rows[i].vlan, rows[i].port, rows[i].stamp,
            rows[i].typed, rows[i].ans);
    drain();

    // Fill the table past capacity so learns of new keys are dropped
    clock_now = $urandom;
    for (int i = 0; i < ENTRIES + 6; i++)
      issue(mlt_pkg::OP_LEARN, 48'({$urandom, $urandom}), 12'($urandom), 8'($urandom),
            clock_now + i);
    for (int i = 0; i < 6; i++)
      issue(mlt_pkg::OP_LOOKUP, slot_mac[$urandom_range(ENTRIES - 1)], '0, '0, clock_now);
    issue(mlt_pkg::OP_AGE, '0, '0, '0, clock_now + 440);
    issue(mlt_pkg::OP_AGE, '0, '0, '0, clock_now + ENTRIES + 400);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 0;
        default: idle_pct = 38;
      endcase
      case (phase)
        0: set_age_limit(16'd0);
        1: set_age_limit(16'hFFFF);
        2: set_age_limit(16'd20);
        3: set_age_limit(16'd300);
        default: set_age_limit(16'($urandom_range(60)));
      endcase
      for (int i = 0; i < 24; i++) begin
        pool_mac[i]  = 48'({$urandom, $urandom});
        pool_vlan[i] = 12'($urandom);
      end
      for (int n = 0; n < 140; n++) begin
        clock_now += ($urandom_range(9) == 0) ? $urandom : $urandom_range(8);
        k = $urandom_range(23);
        m = pool_mac[k];
        v = pool_vlan[k];
        if ($urandom_range(9) == 0) begin
          m = 48'({$urandom, $urandom});
          v = 12'($urandom);
        end
        r = $urandom_range(99);
        if (r < 42)      op = mlt_pkg::OP_LEARN;
        else if (r < 80) op = mlt_pkg::OP_LOOKUP;
        else if (r < 96) op = mlt_pkg::OP_AGE;
        else             op = mlt_pkg::OP_NONE;
        issue(op, m, v, 8'($urandom), clock_now);
        // Let every outstanding result come back before going on
        if (n == 70) drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
